// ----- rtl/lss_pkg.sv -----
package lss_pkg;

    localparam int ActionWidth = 4;
    localparam int StampWidth  = 63;
    localparam int ExitWidth   = 8;
    localparam int StateWidth  = 3;

    // Event codes, shared by request action and delivered event.
    localparam logic [ActionWidth-1:0] EV_PRELOAD  = 4'd0;
    localparam logic [ActionWidth-1:0] EV_START    = 4'd1;
    localparam logic [ActionWidth-1:0] EV_BLUR     = 4'd2;
    localparam logic [ActionWidth-1:0] EV_FOCUS    = 4'd3;
    localparam logic [ActionWidth-1:0] EV_CONCEAL  = 4'd4;
    localparam logic [ActionWidth-1:0] EV_REVEAL   = 4'd5;
    localparam logic [ActionWidth-1:0] EV_FREEZE   = 4'd6;
    localparam logic [ActionWidth-1:0] EV_UNFREEZE = 4'd7;
    localparam logic [ActionWidth-1:0] EV_STOP     = 4'd8;
    localparam logic [ActionWidth-1:0] EV_OTHER    = 4'd9;

    // Lifecycle states.
    localparam logic [StateWidth-1:0] ST_UNSTARTED = 3'd0;
    localparam logic [StateWidth-1:0] ST_STARTED   = 3'd1;
    localparam logic [StateWidth-1:0] ST_BLURRED   = 3'd2;
    localparam logic [StateWidth-1:0] ST_CONCEALED = 3'd3;
    localparam logic [StateWidth-1:0] ST_FROZEN    = 3'd4;
    localparam logic [StateWidth-1:0] ST_STOPPED   = 3'd5;

    typedef struct packed {
        logic [ActionWidth-1:0] action;
        logic [StampWidth-1:0]  stamp;
        logic [ExitWidth-1:0]   exit_code;
    } req_t;

    typedef struct packed {
        logic [ActionWidth-1:0] delivered;
        logic [StampWidth-1:0]  stamp_out;
        logic                   resume_hook;
        logic                   suspend_hook;
        logic [StateWidth-1:0]  new_state;
        logic                   running;
        logic [ExitWidth-1:0]   exit_level;
        logic                   last;
    } rsp_t;

    typedef struct packed {
        logic                   hit;
        logic [ActionWidth-1:0] ev;
    } step_t;

    // Next transition on the way from state s toward the requested action.
    // hit clear means nothing (more) is delivered.
    function automatic step_t next_step(logic [ActionWidth-1:0] action,
                                        logic [StateWidth-1:0] s);
        step_t st;
        st.hit = 1'b0;
        st.ev  = EV_OTHER;
        case (action)
            EV_PRELOAD:
            begin
                st.hit = (s == ST_UNSTARTED);
                st.ev  = EV_PRELOAD;
            end
            EV_START:
            begin
                st.hit = 1'b1;
                st.ev  = (s == ST_UNSTARTED || s == ST_STARTED) ? EV_START : EV_FOCUS;
            end
            EV_BLUR:
            begin
                st.hit = (s == ST_STARTED);
                st.ev  = EV_BLUR;
            end
            EV_FOCUS, EV_REVEAL:
            begin
                if (s == ST_FROZEN)
                begin
                    st.hit = 1'b1;
                    st.ev  = EV_UNFREEZE;
                end
                else if (s == ST_CONCEALED)
                begin
                    st.hit = 1'b1;
                    st.ev  = EV_REVEAL;
                end
                else if (s == ST_BLURRED && action == EV_FOCUS)
                begin
                    st.hit = 1'b1;
                    st.ev  = EV_FOCUS;
                end
            end
            EV_CONCEAL, EV_FREEZE, EV_STOP:
            begin
                if (s == ST_STARTED)
                begin
                    st.hit = 1'b1;
                    st.ev  = EV_BLUR;
                end
                else if (s == ST_BLURRED)
                begin
                    st.hit = 1'b1;
                    st.ev  = EV_CONCEAL;
                end
                else if (s == ST_CONCEALED && action != EV_CONCEAL)
                begin
                    st.hit = 1'b1;
                    st.ev  = EV_FREEZE;
                end
                else if (s == ST_FROZEN && action == EV_STOP)
                begin
                    st.hit = 1'b1;
                    st.ev  = EV_STOP;
                end
            end
            EV_UNFREEZE:
            begin
                st.hit = (s == ST_FROZEN);
                st.ev  = EV_UNFREEZE;
            end
            default:
            begin
                st.hit = 1'b1;
                st.ev  = EV_OTHER;
            end
        endcase
        return st;
    endfunction

    function automatic logic [StateWidth-1:0] state_after(logic [ActionWidth-1:0] ev,
                                                          logic [StateWidth-1:0] s);
        logic [StateWidth-1:0] ns;
        ns = s;
        case (ev)
            EV_PRELOAD:  ns = ST_CONCEALED;
            EV_START:    ns = ST_STARTED;
            EV_BLUR:     ns = ST_BLURRED;
            EV_FOCUS:    ns = ST_STARTED;
            EV_CONCEAL:  ns = ST_CONCEALED;
            EV_REVEAL:   ns = ST_BLURRED;
            EV_FREEZE:   ns = ST_FROZEN;
            EV_UNFREEZE: ns = ST_CONCEALED;
            EV_STOP:     ns = ST_STOPPED;
            default:     ns = s;
        endcase
        return ns;
    endfunction

endpackage

// ----- rtl/lifecycle_state_sequencer_unit.sv -----
// Lifecycle state sequencer.
// Request channel (req_valid/req_ready/req) carries one lifecycle event with
// its timestamp and, for stop, an error level. Response channel
// (rsp_valid/rsp_ready/rsp) carries the transitions the block delivers: zero
// to four per request, in order, the final one marked with last.
// A request sits in a work register; each cycle one transition is computed
// from it and the current state and loaded into the output register.
// Throughput: one transition per cycle while the receiver does not stall; a
// request holds the work register until its final transition goes out or it
// is dropped, and the next request is taken in the cycle its predecessor
// finishes, so single-transition requests stream at one per cycle.
// Reset: state goes to unstarted, stored error level to 0, both registers
// empty. When the receiver stalls, the output register holds its result and
// the work register holds the request; req_ready falls until space frees.
module lifecycle_state_sequencer_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  lss_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output lss_pkg::rsp_t rsp
);

    logic                                 work_valid_reg;
    lss_pkg::req_t                        work_reg;
    logic                                 out_valid_reg;
    lss_pkg::rsp_t                        out_reg;
    logic [lss_pkg::StateWidth-1:0]       life_state_reg;
    logic [lss_pkg::StateWidth-1:0]       life_state_next;
    logic [lss_pkg::ExitWidth-1:0]        stored_exit_reg;
    logic [lss_pkg::ExitWidth-1:0]        stored_exit_next;

    lss_pkg::step_t step;
    lss_pkg::rsp_t  result;
    logic           out_free;
    logic           emit;
    logic           finish;
    logic           is_last;

    always_comb
    begin
        step     = lss_pkg::next_step(work_reg.action, life_state_reg);
        out_free = !out_valid_reg || rsp_ready;
        emit     = work_valid_reg && step.hit && out_free;
        is_last  = (step.ev == work_reg.action) || (work_reg.action == lss_pkg::EV_START)
                   || (step.ev == lss_pkg::EV_OTHER);
        // done with the held request: dropped, or its final transition goes out
        finish   = work_valid_reg && (!step.hit || (emit && is_last));

        life_state_next  = lss_pkg::state_after(step.ev, life_state_reg);
        stored_exit_next = (step.ev == lss_pkg::EV_STOP) ? work_reg.exit_code
                                                         : stored_exit_reg;

        result.delivered    = step.ev;
        result.stamp_out    = work_reg.stamp;
        result.resume_hook  = (step.ev == lss_pkg::EV_UNFREEZE)
                              && (life_state_reg == lss_pkg::ST_FROZEN);
        result.suspend_hook = (step.ev == lss_pkg::EV_FREEZE)
                              && (life_state_reg == lss_pkg::ST_CONCEALED);
        result.new_state    = life_state_next;
        result.running      = (life_state_next != lss_pkg::ST_STOPPED);
        result.exit_level   = stored_exit_next;
        result.last         = is_last;
    end

    assign req_ready = !work_valid_reg || finish;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            life_state_reg  <= lss_pkg::ST_UNSTARTED;
            stored_exit_reg <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
                work_valid_reg <= 1'b1;
            else if (finish)
                work_valid_reg <= 1'b0;

            if (emit)
            begin
                out_valid_reg   <= 1'b1;
                life_state_reg  <= life_state_next;
                stored_exit_reg <= stored_exit_next;
            end
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            work_reg <= req;
        if (emit)
            out_reg <= result;
    end

endmodule

// ----- rtl/lss_checker.sv -----
module lss_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input lss_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input lss_pkg::rsp_t rsp
);

    logic unused_req;
    assign unused_req = req_valid ^ req_ready ^ (^req);

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_running: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.running == (rsp.new_state != lss_pkg::ST_STOPPED))
        else $error("running flag disagrees with state");

    a_resume: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.resume_hook |->
            rsp.delivered == lss_pkg::EV_UNFREEZE && rsp.new_state == lss_pkg::ST_CONCEALED)
        else $error("resume hook on wrong transition");

    a_suspend: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.suspend_hook |->
            rsp.delivered == lss_pkg::EV_FREEZE && rsp.new_state == lss_pkg::ST_FROZEN)
        else $error("suspend hook on wrong transition");

    // a delivered stop is always marked last and leaves the running flag clear
    a_stop_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.delivered == lss_pkg::EV_STOP |->
            rsp.last && !rsp.running)
        else $error("stop delivered without last or still running");

endmodule

bind lifecycle_state_sequencer_unit lss_checker u_lss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
